FILE: sv/omni_wheel_command_limiter_defines.svh
// assertion macros for the omni wheel command limiter
`ifndef OMNI_WHEEL_COMMAND_LIMITER_DEFINES_SVH
`define OMNI_WHEEL_COMMAND_LIMITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/owcl_pkg.sv
// shared types and constants of the omni wheel command limiter
package owcl_pkg;

   localparam logic [2:0] CSR_ROBOT_ID        = 3'd0;
   localparam logic [2:0] CSR_SPEED_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_ACC_LIMIT_FAST  = 3'd2;
   localparam logic [2:0] CSR_ACC_LIMIT_SLOW  = 3'd3;
   localparam logic [2:0] CSR_XY_GAIN_Q16     = 3'd4;
   localparam logic [2:0] CSR_ROT_GAIN_Q16    = 3'd5;

   localparam logic [3:0] HDR_MARK = 4'h4;

   typedef enum logic [3:0] {
      MUL_LX2, MUL_LY2, MUL_TH2, MUL_DX2, MUL_DY2, MUL_L2, MUL_AX2, MUL_AY2,
      MUL_RX, MUL_RY, MUL_TT, MUL_TD, MUL_WA, MUL_WB, MUL_WR
   } mul_sel_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_S2, CAP_S2ACC, CAP_LIM, CAP_D2, CAP_D2ACC, CAP_L2, CAP_AX2,
      CAP_AY2, CAP_RHSX, CAP_RHSY, CAP_QTEST, CAP_WA, CAP_WB, CAP_WR
   } cap_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      cap_type     cap;
      logic        qclear;
      logic        comp;
      logic [2:0]  bit_idx;
      logic        apply;
      logic        store;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic pkt_ok;
      logic need_limit;
      logic rsp_busy;
   } status_type;

endpackage

FILE: sv/owcl_datapath.sv
// datapath: config registers, shared multiplier, limiter search and wheel outputs
module owcl_datapath
   import owcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [47:0] req_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,
   input  cmd_type     cmd,
   output status_type  status
);

   logic [3:0]  robot_id_ff;
   logic [9:0]  threshold_ff;
   logic [7:0]  acc_fast_ff, acc_slow_ff;
   logic [15:0] xy_gain_ff, rot_gain_ff;

   logic signed [9:0]  vx_ff, vy_ff, lx_ff, ly_ff;
   logic signed [11:0] vr_ff;
   logic [19:0] s2_ff, ax2_ff, ay2_ff;
   logic [20:0] d2_ff;
   logic [7:0]  lim_ff, qx_ff, qy_ff;
   logic [15:0] l2_ff;
   logic [35:0] rhsx_ff, rhsy_ff;
   logic signed [28:0] wa_ff, wb_ff, wr_ff;
   logic signed [47:0] prod_ff;
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;

   logic signed [23:0] op_a, op_b;
   logic signed [47:0] prod_in;
   logic signed [10:0] dx, dy, nvx, nvy, sxy_a, sxy_b;
   logic [9:0]  ax, ay;
   logic [7:0]  t_val, q_cur, q_new;
   logic [35:0] rhs_cur;
   logic signed [29:0] sum1, sum2, sum3, sum4;
   logic [7:0]  hdr, id, bvx, bvy, bvr, ext;

   function automatic logic [9:0] wheel_out(input logic signed [29:0] s);
      logic        neg;
      logic [29:0] mag;
      logic [13:0] sh;
      logic [9:0]  r;
      neg = s[29];
      mag = neg ? 30'(-s) : 30'(s);
      sh  = mag[29:16];
      if (!neg) begin
         r = (sh > 14'd511) ? 10'd511 : sh[9:0];
      end else begin
         r = (sh > 14'd512) ? 10'h200 : 10'(-sh[9:0]);
      end
      return r;
   endfunction

   assign hdr = req_tdata[7:0];
   assign id  = req_tdata[15:8];
   assign bvx = req_tdata[23:16];
   assign bvy = req_tdata[31:24];
   assign bvr = req_tdata[39:32];
   assign ext = req_tdata[47:40];

   assign dx = 11'(vx_ff) - 11'(lx_ff);
   assign dy = 11'(vy_ff) - 11'(ly_ff);
   assign ax = dx[10] ? 10'(-dx) : dx[9:0];
   assign ay = dy[10] ? 10'(-dy) : dy[9:0];
   assign nvx = 11'(lx_ff) + (dx[10] ? -11'({3'b0, qx_ff}) : 11'({3'b0, qx_ff}));
   assign nvy = 11'(ly_ff) + (dy[10] ? -11'({3'b0, qy_ff}) : 11'({3'b0, qy_ff}));
   assign sxy_a = 11'(vx_ff) - 11'(vy_ff);
   assign sxy_b = 11'(vx_ff) + 11'(vy_ff);
   assign q_cur = cmd.comp ? qy_ff : qx_ff;
   assign t_val = q_cur | (8'd1 << cmd.bit_idx);
   assign rhs_cur = cmd.comp ? rhsy_ff : rhsx_ff;
   assign q_new = (prod_ff[37:0] <= {2'b0, rhs_cur}) ? t_val : q_cur;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         MUL_LX2: begin op_a = 24'(lx_ff); op_b = 24'(lx_ff); end
         MUL_LY2: begin op_a = 24'(ly_ff); op_b = 24'(ly_ff); end
         MUL_TH2: begin op_a = {14'b0, threshold_ff}; op_b = {14'b0, threshold_ff}; end
         MUL_DX2: begin op_a = 24'(dx); op_b = 24'(dx); end
         MUL_DY2: begin op_a = 24'(dy); op_b = 24'(dy); end
         MUL_L2:  begin op_a = {16'b0, lim_ff}; op_b = {16'b0, lim_ff}; end
         MUL_AX2: begin op_a = {14'b0, ax}; op_b = {14'b0, ax}; end
         MUL_AY2: begin op_a = {14'b0, ay}; op_b = {14'b0, ay}; end
         MUL_RX:  begin op_a = {8'b0, l2_ff}; op_b = {4'b0, ax2_ff}; end
         MUL_RY:  begin op_a = {8'b0, l2_ff}; op_b = {4'b0, ay2_ff}; end
         MUL_TT:  begin op_a = {16'b0, t_val}; op_b = {16'b0, t_val}; end
         MUL_TD:  begin op_a = {8'b0, prod_ff[15:0]}; op_b = {3'b0, d2_ff}; end
         MUL_WA:  begin op_a = 24'(sxy_a); op_b = {8'b0, xy_gain_ff}; end
         MUL_WB:  begin op_a = 24'(sxy_b); op_b = {8'b0, xy_gain_ff}; end
         MUL_WR:  begin op_a = 24'(vr_ff); op_b = {8'b0, rot_gain_ff}; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_in = op_a * op_b;

   assign sum1 = 30'(wa_ff) - 30'(wr_ff);
   assign sum2 = -30'(wb_ff) - 30'(wr_ff);
   assign sum3 = -30'(wa_ff) - 30'(wr_ff);
   assign sum4 = 30'(wb_ff) - 30'(wr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         robot_id_ff  <= 4'd1;
         threshold_ff <= 10'd325;
         acc_fast_ff  <= 8'd25;
         acc_slow_ff  <= 8'd20;
         xy_gain_ff   <= 16'd24124;
         rot_gain_ff  <= 16'd1748;
         lx_ff        <= '0;
         ly_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROBOT_ID:        robot_id_ff  <= csr_wdata[3:0];
               CSR_SPEED_THRESHOLD: threshold_ff <= csr_wdata[9:0];
               CSR_ACC_LIMIT_FAST:  acc_fast_ff  <= csr_wdata[7:0];
               CSR_ACC_LIMIT_SLOW:  acc_slow_ff  <= csr_wdata[7:0];
               CSR_XY_GAIN_Q16:     xy_gain_ff   <= csr_wdata;
               CSR_ROT_GAIN_Q16:    rot_gain_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.store) begin
            lx_ff <= vx_ff;
            ly_ff <= vy_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         vx_ff <= bvx[7] ? -10'({ext[7:6], bvx[6:0]}) : 10'({ext[7:6], bvx[6:0]});
         vy_ff <= bvy[7] ? -10'({ext[5:4], bvy[6:0]}) : 10'({ext[5:4], bvy[6:0]});
         vr_ff <= bvr[7] ? -12'({ext[3:0], bvr[6:0]}) : 12'({ext[3:0], bvr[6:0]});
      end
      if (cmd.apply) begin
         vx_ff <= nvx[9:0];
         vy_ff <= nvy[9:0];
      end
      if (cmd.qclear) begin
         qx_ff <= '0;
         qy_ff <= '0;
      end
      case (cmd.cap)
         CAP_S2:    s2_ff <= prod_ff[19:0];
         CAP_S2ACC: s2_ff <= s2_ff + prod_ff[19:0];
         CAP_LIM:   lim_ff <= (s2_ff > prod_ff[19:0]) ? acc_fast_ff : acc_slow_ff;
         CAP_D2:    d2_ff <= prod_ff[20:0];
         CAP_D2ACC: d2_ff <= d2_ff + prod_ff[20:0];
         CAP_L2:    l2_ff <= prod_ff[15:0];
         CAP_AX2:   ax2_ff <= prod_ff[19:0];
         CAP_AY2:   ay2_ff <= prod_ff[19:0];
         CAP_RHSX:  rhsx_ff <= prod_ff[35:0];
         CAP_RHSY:  rhsy_ff <= prod_ff[35:0];
         CAP_QTEST: begin
            if (cmd.comp) qy_ff <= q_new;
            else qx_ff <= q_new;
         end
         CAP_WA:    wa_ff <= prod_ff[28:0];
         CAP_WB:    wb_ff <= prod_ff[28:0];
         CAP_WR:    wr_ff <= prod_ff[28:0];
         default: ;
      endcase
      if (cmd.emit) begin
         rsp_data_ff <= {wheel_out(sum4), wheel_out(sum3), wheel_out(sum2),
                         wheel_out(sum1)};
      end
   end

   assign status.pkt_ok = (hdr[7:4] == HDR_MARK) && hdr[3] && (id[3:0] == robot_id_ff);
   assign status.need_limit = {1'b0, d2_ff} > {6'b0, l2_ff};
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/owcl_ctrl.sv
// controller: sequences the shared multiplier through limiting and wheel mixing
module owcl_ctrl
   import owcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SX, ST_SY, ST_TH, ST_LIM, ST_DY, ST_L2, ST_AX, ST_AY, ST_RX,
      ST_RY, ST_CHK, ST_QA, ST_QB, ST_QC, ST_APPLY, ST_WA, ST_WB, ST_WR,
      ST_WCAP, ST_FIN
   } state_type;

   state_type  state_ff;
   logic [2:0] bit_ff;
   logic       comp_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_LX2;
      cmd.cap = CAP_NONE;
      cmd.comp = comp_ff;
      cmd.bit_idx = bit_ff;
      case (state_ff)
         ST_IDLE:  cmd.load = req_tvalid && status.pkt_ok;
         ST_SX:    cmd.mul_sel = MUL_LX2;
         ST_SY:    begin cmd.mul_sel = MUL_LY2; cmd.cap = CAP_S2; end
         ST_TH:    begin cmd.mul_sel = MUL_TH2; cmd.cap = CAP_S2ACC; end
         ST_LIM:   begin cmd.mul_sel = MUL_DX2; cmd.cap = CAP_LIM; end
         ST_DY:    begin cmd.mul_sel = MUL_DY2; cmd.cap = CAP_D2; end
         ST_L2:    begin cmd.mul_sel = MUL_L2; cmd.cap = CAP_D2ACC; end
         ST_AX:    begin cmd.mul_sel = MUL_AX2; cmd.cap = CAP_L2; end
         ST_AY:    begin cmd.mul_sel = MUL_AY2; cmd.cap = CAP_AX2; end
         ST_RX:    begin cmd.mul_sel = MUL_RX; cmd.cap = CAP_AY2; end
         ST_RY:    begin cmd.mul_sel = MUL_RY; cmd.cap = CAP_RHSX; end
         ST_CHK:   begin cmd.cap = CAP_RHSY; cmd.qclear = 1'b1; end
         ST_QA:    cmd.mul_sel = MUL_TT;
         ST_QB:    cmd.mul_sel = MUL_TD;
         ST_QC:    cmd.cap = CAP_QTEST;
         ST_APPLY: cmd.apply = 1'b1;
         ST_WA:    begin cmd.mul_sel = MUL_WA; cmd.store = 1'b1; end
         ST_WB:    begin cmd.mul_sel = MUL_WB; cmd.cap = CAP_WA; end
         ST_WR:    begin cmd.mul_sel = MUL_WR; cmd.cap = CAP_WB; end
         ST_WCAP:  cmd.cap = CAP_WR;
         ST_FIN:   cmd.emit = !status.rsp_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
         comp_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE:  if (req_tvalid && status.pkt_ok) state_ff <= ST_SX;
            ST_SX:    state_ff <= ST_SY;
            ST_SY:    state_ff <= ST_TH;
            ST_TH:    state_ff <= ST_LIM;
            ST_LIM:   state_ff <= ST_DY;
            ST_DY:    state_ff <= ST_L2;
            ST_L2:    state_ff <= ST_AX;
            ST_AX:    state_ff <= ST_AY;
            ST_AY:    state_ff <= ST_RX;
            ST_RX:    state_ff <= ST_RY;
            ST_RY:    state_ff <= ST_CHK;
            ST_CHK: begin
               bit_ff   <= 3'd7;
               comp_ff  <= 1'b0;
               state_ff <= status.need_limit ? ST_QA : ST_WA;
            end
            ST_QA:    state_ff <= ST_QB;
            ST_QB:    state_ff <= ST_QC;
            ST_QC: begin
               if (bit_ff != 3'd0) begin
                  bit_ff   <= bit_ff - 3'd1;
                  state_ff <= ST_QA;
               end else if (!comp_ff) begin
                  comp_ff  <= 1'b1;
                  bit_ff   <= 3'd7;
                  state_ff <= ST_QA;
               end else begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: state_ff <= ST_WA;
            ST_WA:    state_ff <= ST_WB;
            ST_WB:    state_ff <= ST_WR;
            ST_WR:    state_ff <= ST_WCAP;
            ST_WCAP:  state_ff <= ST_FIN;
            ST_FIN:   if (!status.rsp_busy) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/omni_wheel_command_limiter.sv
// top level of the omni wheel command limiter
// One command packet per transfer. A packet with a bad header or another robot id is
// taken and dropped. An accepted packet occupies the block from ST_SX through ST_FIN,
// passing through the search states only when the velocity change exceeds the
// acceleration limit, and it stays in ST_FIN while the previous wheel speeds still wait
// in the output register once the new ones are ready. The occupancy is set by the single
// shared 24x24 multiplier, which computes every square, the scaled limit and the wheel
// products one at a time, and by the bitwise search for each limited component (ST_QA,
// ST_QB and ST_QC for each bit, eight bits, two components). The next packet is taken as
// soon as the wheel speeds are in the output register, while they wait to be taken.
`include "omni_wheel_command_limiter_defines.svh"
module omni_wheel_command_limiter
   import owcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // header_byte, id_byte, vx_byte, vy_byte, vr_byte, extension_byte
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // wheel_one, wheel_two, wheel_three, wheel_four
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   owcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   owcl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   `ASSERT_NEXT(a_emit_shows, cmd.emit, rsp_tvalid)
   `ASSERT_IMPL(a_load_when_ready, cmd.load, req_tready && req_tvalid)
   `ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.load, cmd.apply, cmd.store, cmd.emit}))

endmodule

FILE: dv/omni_wheel_command_limiter_test.sv
// testbench for the omni wheel command limiter: packet acceptance, limiting and wheel speeds
module omni_wheel_command_limiter_test;
   import owcl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] ext;
      logic [7:0] vr;
      logic [7:0] vy;
      logic [7:0] vx;
      logic [7:0] id;
      logic [7:0] hdr;
   } packet_t;

   typedef struct packed {
      logic signed [9:0] w4;
      logic signed [9:0] w3;
      logic signed [9:0] w2;
      logic signed [9:0] w1;
   } wheels_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   omni_wheel_command_limiter DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow copy of the registers and stored velocity
   logic [3:0]  id_reg;
   logic [9:0]  thresh_reg;
   logic [7:0]  fast_reg, slow_reg;
   logic [15:0] xy_gain_reg, rot_gain_reg;
   int          prev_vx, prev_vy;

   wheels_t     wheel_queue[$];
   int          errors = 0;
   int          packets_sent = 0, packets_taken = 0, results_seen = 0, limited_count = 0;
   int          idle_pct = 37;
   bit          hold_rsp = 0;
   longint      cycle_count = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      errors++;
   endtask

   function automatic int decode_sm(input logic [7:0] b, input int hi);
      int mag;
      mag = int'(b[6:0]) | (hi << 7);
      return b[7] ? -mag : mag;
   endfunction

   function automatic int clamp_comp(input int c, input longint d2, input longint lim);
      longint a, rhs, q, t;
      a = c < 0 ? -c : c;
      rhs = lim * lim * a * a;
      q = 0;
      for (int b = 128; b != 0; b >>= 1) begin
         t = q | b;
         if (t * t * d2 <= rhs) q = t;
      end
      return c < 0 ? -int'(q) : int'(q);
   endfunction

   function automatic logic [9:0] wheel_speed(input int lin, input int vr);
      longint sum, r;
      sum = longint'(lin) * longint'(xy_gain_reg) - longint'(vr) * longint'(rot_gain_reg);
      r = sum < 0 ? -((-sum) >>> 16) : (sum >>> 16);
      if (r > 511) r = 511;
      if (r < -512) r = -512;
      return r[9:0];
   endfunction

   function automatic void predict_wheels(input packet_t p);
      int vx, vy, vr, dx, dy;
      longint s2, d2, lim;
      wheels_t w;
      if (p.hdr[7:4] != HDR_MARK || !p.hdr[3] || p.id[3:0] != id_reg) return;
      vx = decode_sm(p.vx, p.ext[7:6]);
      vy = decode_sm(p.vy, p.ext[5:4]);
      vr = decode_sm(p.vr, p.ext[3:0]);
      s2 = longint'(prev_vx) * prev_vx + longint'(prev_vy) * prev_vy;
      lim = (s2 > longint'(thresh_reg) * thresh_reg) ? fast_reg : slow_reg;
      dx = vx - prev_vx;
      dy = vy - prev_vy;
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      if (d2 > lim * lim) begin
         vx = prev_vx + clamp_comp(dx, d2, lim);
         vy = prev_vy + clamp_comp(dy, d2, lim);
         limited_count++;
      end
      prev_vx = vx;
      prev_vy = vy;
      w.w1 = wheel_speed(vx - vy, vr);
      w.w2 = wheel_speed(-vx - vy, vr);
      w.w3 = wheel_speed(-vx + vy, vr);
      w.w4 = wheel_speed(vx + vy, vr);
      wheel_queue.push_back(w);
   endfunction

   task automatic send_packet(input packet_t p);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clock);
      req_tvalid = 1;
      req_tdata = p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_wheels(p);
      packets_sent++;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         CSR_ROBOT_ID:        id_reg = val[3:0];
         CSR_SPEED_THRESHOLD: thresh_reg = val[9:0];
         CSR_ACC_LIMIT_FAST:  fast_reg = val[7:0];
         CSR_ACC_LIMIT_SLOW:  slow_reg = val[7:0];
         CSR_XY_GAIN_Q16:     xy_gain_reg = val;
         CSR_ROT_GAIN_Q16:    rot_gain_reg = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (wheel_queue.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic packet_t good_packet();
      packet_t p;
      p = 48'({$urandom, $urandom});
      p.hdr[7:4] = HDR_MARK;
      p.hdr[3] = 1;
      p.id[3:0] = id_reg;
      return p;
   endfunction

   function automatic packet_t make_packet(input int vx, input int vy, input int vr);
      packet_t p;
      int ax, ay, ar;
      p = good_packet();
      ax = vx < 0 ? -vx : vx;
      ay = vy < 0 ? -vy : vy;
      ar = vr < 0 ? -vr : vr;
      p.vx = {vx < 0, 7'(ax)};
      p.vy = {vy < 0, 7'(ay)};
      p.vr = {vr < 0, 7'(ar)};
      p.ext = {2'(ax >> 7), 2'(ay >> 7), 4'(ar >> 7)};
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      wheels_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (wheel_queue.size() == 0) begin
            report("unexpected wheel transfer", 1, 0);
         end else begin
            want = wheel_queue.pop_front();
            if (got.w1 != want.w1) report("wheel_one", got.w1, want.w1);
            if (got.w2 != want.w2) report("wheel_two", got.w2, want.w2);
            if (got.w3 != want.w3) report("wheel_three", got.w3, want.w3);
            if (got.w4 != want.w4) report("wheel_four", got.w4, want.w4);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if (idle_pct == 0) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 600000) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_directed();
      int mags[] = '{0, 1, 511, -511, 300, -300};
      packet_t p;
      // negative zero, extremes, reject cases
      p = make_packet(0, 0, 0);
      p.vx[7] = 1; p.vy[7] = 1; p.vr[7] = 1;
      send_packet(p);
      foreach (mags[i]) send_packet(make_packet(mags[i], -mags[i], i[0] ? 2047 : -2047));
      p = good_packet(); p.hdr[7:4] = 4'h5; send_packet(p);
      p = good_packet(); p.hdr[3] = 0; send_packet(p);
      p = good_packet(); p.id[3:0] = 4'(id_reg + 4'd1); send_packet(p);
      send_packet('1);
      send_packet('0);
      for (int i = 0; i < 8; i++) send_packet(make_packet(511, 511, 0));
      send_packet(make_packet(prev_vx, prev_vy, 5));
      drain();
   endtask

   task automatic test_config_sweep();
      write_reg(CSR_ROBOT_ID, 16'd15);
      write_reg(CSR_SPEED_THRESHOLD, 16'd0);
      write_reg(CSR_ACC_LIMIT_FAST, 16'd255);
      write_reg(CSR_ACC_LIMIT_SLOW, 16'd0);
      write_reg(CSR_XY_GAIN_Q16, 16'hffff);
      write_reg(CSR_ROT_GAIN_Q16, 16'hffff);
      write_reg(CSR_UNUSED, 16'h1234);
      for (int i = 0; i < 20; i++)
         send_packet(make_packet($urandom_range(1022) - 511, $urandom_range(1022) - 511,
                                 $urandom_range(4094) - 2047));
      drain();
      write_reg(CSR_ROBOT_ID, 16'd0);
      write_reg(CSR_SPEED_THRESHOLD, 16'd1023);
      write_reg(CSR_ACC_LIMIT_FAST, 16'd0);
      write_reg(CSR_ACC_LIMIT_SLOW, 16'd255);
      write_reg(CSR_XY_GAIN_Q16, 16'd0);
      write_reg(CSR_ROT_GAIN_Q16, 16'd0);
      for (int i = 0; i < 20; i++) send_packet(good_packet());
      drain();
   endtask

   task automatic test_random(input int count);
      packet_t p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(9) < 8 ? good_packet() : packet_t'(48'({$urandom, $urandom}));
         if ($urandom_range(3) == 0) p = make_packet(prev_vx + $urandom_range(60) - 30,
                                                     prev_vy + $urandom_range(60) - 30,
                                                     $urandom_range(4094) - 2047);
         send_packet(p);
      end
      drain();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 10; i++) send_packet(good_packet());
      join
      drain();
   endtask

   initial begin
      id_reg = 1; thresh_reg = 325; fast_reg = 25; slow_reg = 20;
      xy_gain_reg = 24124; rot_gain_reg = 1748;
      prev_vx = 0; prev_vy = 0;
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_directed();
      test_config_sweep();
      write_reg(CSR_ROBOT_ID, 16'($urandom_range(15)));
      write_reg(CSR_SPEED_THRESHOLD, 16'(100 + $urandom_range(400)));
      write_reg(CSR_ACC_LIMIT_FAST, 16'(10 + $urandom_range(100)));
      write_reg(CSR_ACC_LIMIT_SLOW, 16'(5 + $urandom_range(60)));
      write_reg(CSR_XY_GAIN_Q16, 16'd24124);
      write_reg(CSR_ROT_GAIN_Q16, 16'd1748);
      test_random(600);
      idle_pct = 0;
      test_random(200);
      idle_pct = 37;
      test_backpressure();
      write_reg(CSR_XY_GAIN_Q16, 16'($urandom));
      write_reg(CSR_ROT_GAIN_Q16, 16'($urandom));
      test_random(480);
      $display("sent %0d packets, %0d wheel results checked, %0d limited",
               packets_sent, results_seen, limited_count);
      $display("covered reject paths, register extremes, output stall and random gains");
      if (errors == 0 && wheel_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+sv
sv/owcl_pkg.sv
sv/owcl_datapath.sv
sv/owcl_ctrl.sv
sv/omni_wheel_command_limiter.sv
dv/omni_wheel_command_limiter_test.sv
